>>> rtl/tss_pkg.sv
`timescale 1ns / 1ps
package tss_pkg;

   localparam int CW = 16;        // coordinate width
   localparam int DW = CW + 1;    // width of a coordinate difference
   localparam int PW = 2 * DW;    // width of an edge product
   localparam int QW = DW;        // quotient bits, one divider stage each

   typedef struct packed {
      logic signed [CW-1:0] vert_a_x;
      logic signed [CW-1:0] vert_a_y;
      logic signed [CW-1:0] vert_b_x;
      logic signed [CW-1:0] vert_b_y;
      logic signed [CW-1:0] vert_c_x;
      logic signed [CW-1:0] vert_c_y;
      logic signed [CW-1:0] row;
      logic [31:0]          fill_color;
   } tss_req_type;

   typedef struct packed {
      logic                 span_valid;
      logic signed [CW-1:0] span_left;
      logic signed [CW-1:0] span_right;
      logic [31:0]          span_color;
   } tss_rsp_type;

   // One edge evaluation: xs + (dx * dt) / dy, with dy never negative and zero only on rows outside the triangle.
   typedef struct packed {
      logic signed [DW-1:0] dx;
      logic signed [DW-1:0] dt;
      logic [DW-1:0]        dy;
      logic signed [CW-1:0] xs;
   } tss_edge_type;

   typedef struct packed {
      logic                 span_valid;
      logic                 flat;
      logic signed [CW-1:0] flat_min;
      logic signed [CW-1:0] flat_max;
      logic signed [CW-1:0] xs_a;
      logic signed [CW-1:0] xs_b;
      logic [31:0]          color;
   } tss_side_type;

endpackage

>>> rtl/tss_setup.sv
`timescale 1ns / 1ps
module tss_setup (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  tss_pkg::tss_req_type  in_data,
   output logic                  out_valid,
   output tss_pkg::tss_edge_type out_edge_a,
   output tss_pkg::tss_edge_type out_edge_b,
   output tss_pkg::tss_side_type out_side
);
   import tss_pkg::*;

   logic signed [CW-1:0] sx [3];
   logic signed [CW-1:0] sy [3];
   logic signed [CW-1:0] tx;
   logic signed [CW-1:0] ty;

   logic signed [CW-1:0] x_ff [3];
   logic signed [CW-1:0] y_ff [3];
   logic signed [CW-1:0] row_ff;
   logic [31:0]          color_ff;
   logic                 v1_ff;

   tss_edge_type edge_a_in, edge_a_ff;
   tss_edge_type edge_b_in, edge_b_ff;
   tss_side_type side_in, side_ff;
   logic         v2_ff;

   logic signed [DW-1:0] ex [3];
   logic signed [DW-1:0] ey [3];
   logic signed [DW-1:0] er;
   logic signed [DW-1:0] dy_b;
   logic signed [CW-1:0] mn;
   logic signed [CW-1:0] mx;
   logic                 flat;

   // Three compare-exchange steps; equal rows keep their input order.
   always_comb begin
      tx    = '0;
      ty    = '0;
      sx[0] = in_data.vert_a_x;
      sy[0] = in_data.vert_a_y;
      sx[1] = in_data.vert_b_x;
      sy[1] = in_data.vert_b_y;
      sx[2] = in_data.vert_c_x;
      sy[2] = in_data.vert_c_y;
      if (sy[0] > sy[1]) begin
         tx = sx[0]; sx[0] = sx[1]; sx[1] = tx;
         ty = sy[0]; sy[0] = sy[1]; sy[1] = ty;
      end
      if (sy[1] > sy[2]) begin
         tx = sx[1]; sx[1] = sx[2]; sx[2] = tx;
         ty = sy[1]; sy[1] = sy[2]; sy[2] = ty;
      end
      if (sy[0] > sy[1]) begin
         tx = sx[0]; sx[0] = sx[1]; sx[1] = tx;
         ty = sy[0]; sy[0] = sy[1]; sy[1] = ty;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
      end
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            x_ff[i] <= sx[i];
            y_ff[i] <= sy[i];
         end
         row_ff   <= in_data.row;
         color_ff <= in_data.fill_color;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ex[i] = {x_ff[i][CW-1], x_ff[i]};
         ey[i] = {y_ff[i][CW-1], y_ff[i]};
      end
      er   = {row_ff[CW-1], row_ff};
      flat = (y_ff[0] == y_ff[2]);

      mn = x_ff[0];
      mx = x_ff[0];
      if (x_ff[1] < mn) mn = x_ff[1];
      if (x_ff[2] < mn) mn = x_ff[2];
      if (x_ff[1] > mx) mx = x_ff[1];
      if (x_ff[2] > mx) mx = x_ff[2];

      // Long edge from top to bottom; a flat triangle never uses it.
      dy_b          = ey[2] - ey[0];
      edge_b_in.xs  = x_ff[0];
      edge_b_in.dt  = er - ey[0];
      edge_b_in.dx  = flat ? '0 : ex[2] - ex[0];
      edge_b_in.dy  = flat ? DW'(1) : dy_b;

      if (row_ff < y_ff[1]) begin
         edge_a_in.xs = x_ff[0];
         edge_a_in.dx = ex[1] - ex[0];
         edge_a_in.dy = ey[1] - ey[0];
         edge_a_in.dt = er - ey[0];
      end else if (y_ff[1] != y_ff[2]) begin
         edge_a_in.xs = x_ff[1];
         edge_a_in.dx = ex[2] - ex[1];
         edge_a_in.dy = ey[2] - ey[1];
         edge_a_in.dt = er - ey[1];
      end else begin
         // Middle and bottom rows equal: the short side sits at the middle column.
         edge_a_in.xs = x_ff[1];
         edge_a_in.dx = '0;
         edge_a_in.dy = DW'(1);
         edge_a_in.dt = '0;
      end

      side_in.flat       = flat;
      side_in.span_valid = flat ? (row_ff == y_ff[0])
                                : (row_ff >= y_ff[0]) && (row_ff <= y_ff[2]);
      side_in.flat_min   = mn;
      side_in.flat_max   = mx;
      side_in.xs_a       = edge_a_in.xs;
      side_in.xs_b       = edge_b_in.xs;
      side_in.color      = color_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
      end
      if (advance) begin
         edge_a_ff <= edge_a_in;
         edge_b_ff <= edge_b_in;
         side_ff   <= side_in;
      end
   end

   assign out_valid  = v2_ff;
   assign out_edge_a = edge_a_ff;
   assign out_edge_b = edge_b_ff;
   assign out_side   = side_ff;

endmodule

>>> rtl/tss_div.sv
`timescale 1ns / 1ps
module tss_div (
   input  logic                          clock,
   input  logic                          advance,
   input  logic signed [tss_pkg::PW-1:0] dividend,
   input  logic [tss_pkg::DW-1:0]        divisor,
   output logic signed [tss_pkg::DW-1:0] quotient
);
   import tss_pkg::*;

   logic [PW-1:0] mag;
   logic [DW-1:0] rem_ff [QW+1];
   logic [QW-1:0] low_ff [QW+1];
   logic [DW-1:0] dvs_ff [QW+1];
   logic          neg_ff [QW+1];
   logic [DW-1:0] rem_in [QW];
   logic [QW-1:0] low_in [QW];
   logic [DW:0]   trial  [QW];
   logic [DW:0]   diff   [QW];

   assign mag = dividend[PW-1] ? PW'(-dividend) : PW'(dividend);

   // On rows inside the triangle the quotient fits in QW bits, so the high part of the
   // magnitude is already below the divisor and only the low QW bits need a step.
   always_comb begin
      for (int i = 0; i < QW; i++) begin
         trial[i]  = {rem_ff[i], low_ff[i][QW-1]};
         diff[i]   = trial[i] - {1'b0, dvs_ff[i]};
         if (trial[i] >= {1'b0, dvs_ff[i]}) begin
            rem_in[i] = diff[i][DW-1:0];
            low_in[i] = {low_ff[i][QW-2:0], 1'b1};
         end else begin
            rem_in[i] = trial[i][DW-1:0];
            low_in[i] = {low_ff[i][QW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0] <= mag[PW-1:QW];
         low_ff[0] <= mag[QW-1:0];
         dvs_ff[0] <= divisor;
         neg_ff[0] <= dividend[PW-1];
         for (int i = 0; i < QW; i++) begin
            rem_ff[i+1] <= rem_in[i];
            low_ff[i+1] <= low_in[i];
            dvs_ff[i+1] <= dvs_ff[i];
            neg_ff[i+1] <= neg_ff[i];
         end
      end
   end

   assign quotient = neg_ff[QW] ? DW'(-low_ff[QW]) : DW'(low_ff[QW]);

endmodule

>>> rtl/triangle_scanline_span_unit.sv
`timescale 1ns / 1ps
// Channel  Ports                          Direction  Payload
// req      req_valid req_ready req_data   in         three vertices, row, color
// rsp      rsp_valid rsp_ready rsp_data   out        span valid, left, right, color
//
// One item enters per cycle unless the pipeline holds; the divider resolves one
// quotient bit per stage. Reset clears only the valid bits. When rsp_valid is high
// and rsp_ready low, the whole pipeline holds, and req_ready drops with it.
module triangle_scanline_span_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tss_pkg::tss_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tss_pkg::tss_rsp_type rsp_data
);
   import tss_pkg::*;

   logic         advance;
   logic         su_valid;
   tss_edge_type su_edge_a;
   tss_edge_type su_edge_b;
   tss_side_type su_side;

   logic signed [PW-1:0] prod_a_ff;
   logic signed [PW-1:0] prod_b_ff;
   logic [DW-1:0]        dy_a_ff;
   logic [DW-1:0]        dy_b_ff;
   tss_side_type         side3_ff;
   logic                 v3_ff;

   tss_side_type side_ff [QW+1];
   logic         vld_ff  [QW+1];

   logic signed [DW-1:0] q_a;
   logic signed [DW-1:0] q_b;
   logic signed [CW-1:0] xa;
   logic signed [CW-1:0] xb;
   tss_side_type         fin;
   tss_rsp_type          rsp_in;
   tss_rsp_type          rsp_ff;
   logic                 rsp_valid_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   tss_setup u_setup (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_valid),
      .in_data    (req_data),
      .out_valid  (su_valid),
      .out_edge_a (su_edge_a),
      .out_edge_b (su_edge_b),
      .out_side   (su_side)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         for (int i = 0; i <= QW; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         v3_ff     <= su_valid;
         vld_ff[0] <= v3_ff;
         for (int i = 0; i < QW; i++) begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end
      if (advance) begin
         prod_a_ff  <= PW'(su_edge_a.dx * su_edge_a.dt);
         prod_b_ff  <= PW'(su_edge_b.dx * su_edge_b.dt);
         dy_a_ff    <= su_edge_a.dy;
         dy_b_ff    <= su_edge_b.dy;
         side3_ff   <= su_side;
         side_ff[0] <= side3_ff;
         for (int i = 0; i < QW; i++) begin
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   tss_div u_div_a (
      .clock    (clock),
      .advance  (advance),
      .dividend (prod_a_ff),
      .divisor  (dy_a_ff),
      .quotient (q_a)
   );

   tss_div u_div_b (
      .clock    (clock),
      .advance  (advance),
      .dividend (prod_b_ff),
      .divisor  (dy_b_ff),
      .quotient (q_b)
   );

   always_comb begin
      fin = side_ff[QW];
      xa  = fin.xs_a + q_a[CW-1:0];
      xb  = fin.xs_b + q_b[CW-1:0];
      rsp_in.span_valid = fin.span_valid;
      rsp_in.span_color = fin.color;
      if (!fin.span_valid) begin
         rsp_in.span_left  = '0;
         rsp_in.span_right = '0;
      end else if (fin.flat) begin
         rsp_in.span_left  = fin.flat_min;
         rsp_in.span_right = fin.flat_max;
      end else if (xa > xb) begin
         rsp_in.span_left  = xb;
         rsp_in.span_right = xa;
      end else begin
         rsp_in.span_left  = xa;
         rsp_in.span_right = xb;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= vld_ff[QW];
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_ready_follows_output: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready does not follow the output stage");

   a_invalid_span_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.span_valid |->
         rsp_data.span_left == '0 && rsp_data.span_right == '0)
      else $error("invalid span with nonzero ends");

   a_span_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.span_valid |-> rsp_data.span_left <= rsp_data.span_right)
      else $error("span ends out of order");

endmodule

>>> verif/triangle_scanline_span_unit_test.sv
`timescale 1ns / 1ps
module triangle_scanline_span_unit_test;
   import tss_pkg::*;

   localparam int LATENCY     = QW + 4;
   localparam int STALL_LIMIT = 20000;
   localparam int HOLD_LEN    = 150;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   tss_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   tss_rsp_type rsp_data;

   tss_rsp_type pending_spans[$];
   int          error_count;
   int          span_count;
   int          valid_span_count;
   int          flat_count;
   int          idle_pct;
   int          hold_request;
   int          hold_done;
   int          hold_cycles;
   int          quiet_cycles;

   triangle_scanline_span_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Edge x at row r, truncating toward zero; dy is known to be positive.
   function automatic longint edge_column(longint xs, longint ys, longint xe, longint ye,
                                          longint r);
      longint num;
      longint q;
      num = (xe - xs) * (r - ys);
      q = (num < 0) ? -((-num) / (ye - ys)) : num / (ye - ys);
      return xs + q;
   endfunction

   function automatic tss_rsp_type predict_span(tss_req_type rq);
      tss_rsp_type sp;
      longint x1, y1, x2, y2, x3, y3, r, t, xa, xb;
      x1 = longint'(rq.vert_a_x); y1 = longint'(rq.vert_a_y);
      x2 = longint'(rq.vert_b_x); y2 = longint'(rq.vert_b_y);
      x3 = longint'(rq.vert_c_x); y3 = longint'(rq.vert_c_y);
      r  = longint'(rq.row);
      if (y1 > y2) begin
         t = x1; x1 = x2; x2 = t; t = y1; y1 = y2; y2 = t;
      end
      if (y2 > y3) begin
         t = x2; x2 = x3; x3 = t; t = y2; y2 = y3; y3 = t;
      end
      if (y1 > y2) begin
         t = x1; x1 = x2; x2 = t; t = y1; y1 = y2; y2 = t;
      end
      sp = '0;
      sp.span_color = rq.fill_color;
      if (y1 == y3) begin
         if (r == y1) begin
            xa = x1; xb = x1;
            if (x2 < xa) xa = x2;
            if (x3 < xa) xa = x3;
            if (x2 > xb) xb = x2;
            if (x3 > xb) xb = x3;
            sp.span_valid = 1'b1;
            sp.span_left  = xa[CW-1:0];
            sp.span_right = xb[CW-1:0];
         end
      end else if (r >= y1 && r <= y3) begin
         xb = edge_column(x1, y1, x3, y3, r);
         if (r < y2) xa = edge_column(x1, y1, x2, y2, r);
         else if (y2 != y3) xa = edge_column(x2, y2, x3, y3, r);
         else xa = x2;
         if (xa > xb) begin
            t = xa; xa = xb; xb = t;
         end
         sp.span_valid = 1'b1;
         sp.span_left  = xa[CW-1:0];
         sp.span_right = xb[CW-1:0];
      end
      return sp;
   endfunction

   task automatic send_triangle(input tss_req_type rq);
      while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_spans.push_back(predict_span(rq));
      if (rq.vert_a_y == rq.vert_b_y && rq.vert_b_y == rq.vert_c_y) flat_count++;
   endtask

   function automatic tss_req_type make_triangle(int x1, int y1, int x2, int y2, int x3,
                                                 int y3, int r);
      tss_req_type rq;
      rq.vert_a_x = x1[CW-1:0]; rq.vert_a_y = y1[CW-1:0];
      rq.vert_b_x = x2[CW-1:0]; rq.vert_b_y = y2[CW-1:0];
      rq.vert_c_x = x3[CW-1:0]; rq.vert_c_y = y3[CW-1:0];
      rq.row = r[CW-1:0];
      rq.fill_color = $urandom;
      return rq;
   endfunction

   // Mostly small triangles with rows inside them, sometimes full-range noise.
   function automatic tss_req_type random_triangle();
      tss_req_type rq;
      logic [159:0] noise;
      int base, spread, lo, hi;
      if ($urandom_range(9, 0) == 0) begin
         noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
         rq = noise[$bits(tss_req_type)-1:0];
         return rq;
      end
      spread = ($urandom_range(3, 0) == 0) ? 32767 : $urandom_range(64, 1);
      base = $signed($urandom_range(65535, 0)) - 32768;
      rq.vert_a_x = CW'($urandom); rq.vert_b_x = CW'($urandom); rq.vert_c_x = CW'($urandom);
      if (spread < 32767) begin
         rq.vert_a_x = CW'(base + $urandom_range(2 * spread, 0) - spread);
         rq.vert_b_x = CW'(base + $urandom_range(2 * spread, 0) - spread);
         rq.vert_c_x = CW'(base + $urandom_range(2 * spread, 0) - spread);
         base = $urandom_range(60000, 0) - 30000;
         rq.vert_a_y = CW'(base + $urandom_range(spread, 0));
         rq.vert_b_y = ($urandom_range(5, 0) == 0) ? rq.vert_a_y
                                                    : CW'(base + $urandom_range(spread, 0));
         rq.vert_c_y = CW'(base + $urandom_range(spread, 0));
      end else begin
         rq.vert_a_y = CW'($urandom); rq.vert_b_y = CW'($urandom);
         rq.vert_c_y = CW'($urandom);
      end
      lo = int'(rq.vert_a_y); hi = int'(rq.vert_a_y);
      if (rq.vert_b_y < lo) lo = int'(rq.vert_b_y);
      if (rq.vert_c_y < lo) lo = int'(rq.vert_c_y);
      if (rq.vert_b_y > hi) hi = int'(rq.vert_b_y);
      if (rq.vert_c_y > hi) hi = int'(rq.vert_c_y);
      case ($urandom_range(7, 0))
         0: rq.row = CW'(lo - 1);
         1: rq.row = CW'(hi + 1);
         2: rq.row = CW'(lo);
         3: rq.row = CW'(hi);
         default: rq.row = CW'(lo + $urandom_range(hi - lo, 0));
      endcase
      rq.fill_color = $urandom;
      return rq;
   endfunction

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_spans.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic test_directed();
      int mx, mn;
      mx = 32767; mn = -32768;
      send_triangle(make_triangle(0, 0, 10, 10, -10, 10, 5));
      send_triangle(make_triangle(0, 0, 10, 10, -10, 10, 0));
      send_triangle(make_triangle(0, 0, 10, 10, -10, 10, 10));
      send_triangle(make_triangle(0, 0, 10, 10, -10, 10, 11));
      send_triangle(make_triangle(0, 0, 10, 10, -10, 10, -1));
      send_triangle(make_triangle(5, 3, -7, 3, 20, 3, 3));
      send_triangle(make_triangle(5, 3, -7, 3, 20, 3, 4));
      send_triangle(make_triangle(mn, mn, mx, mn, 0, mn, mn));
      send_triangle(make_triangle(0, 0, 7, 9, -3, 9, 9));
      send_triangle(make_triangle(-3, 9, 0, 0, 7, 9, 9));
      send_triangle(make_triangle(1, 7, 2, 7, 30, -4, 2));
      send_triangle(make_triangle(mn, mn, mx, mx, mn, mx, 0));
      send_triangle(make_triangle(mx, mn, mn, mx, mx, mx, 1));
      send_triangle(make_triangle(mn, mn, mx, mx, mn, mx, mx));
      send_triangle(make_triangle(mx, mx, mn, mn, mx, mn, mn));
      send_triangle(make_triangle(0, mn, -1, mx, 1, 0, -12345));
      send_triangle(make_triangle(3, 0, 0, 7, 5, 3, 2));
      send_triangle(make_triangle(-3, 0, 0, -7, -5, -3, -2));
      send_triangle(make_triangle(mx, 0, mx, 1, mx, 2, 1));
      send_triangle(make_triangle(0, 0, 0, 0, 0, 0, 0));
      send_triangle(make_triangle(-1, -1, -1, -1, -1, -1, -1));
   endtask

   task automatic test_random(input int count);
      repeat (count) send_triangle(random_triangle());
   endtask

   task automatic test_back_to_back();
      idle_pct = 0;
      repeat (300) send_triangle(random_triangle());
      idle_pct = 11;
   endtask

   task automatic test_output_hold();
      hold_request++;
      repeat (80) send_triangle(random_triangle());
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      idle_pct     = 11;
      hold_request = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      wait_drained();
      test_random(450);
      test_back_to_back();
      test_output_hold();
      wait_drained();
      test_random(450);
      wait_drained();
      $display("Checked %0d spans (%0d inside the triangle, %0d flat triangles sent).",
               span_count, valid_span_count, flat_count);
      $display("Covered directed corners, random triangles, back-to-back items and a long output stall.");
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // The receiver counts its own long hold once the sender asks for one.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready   <= 1'b0;
         hold_cycles <= 0;
         hold_done   <= 0;
      end else if (hold_request != hold_done) begin
         rsp_ready   <= 1'b0;
         hold_cycles <= HOLD_LEN;
         hold_done   <= hold_request;
      end else if (hold_cycles > 0) begin
         rsp_ready   <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_ready <= (idle_pct == 0) || ($urandom_range(99, 0) >= 11);
      end
   end

   always @(posedge clock) begin
      tss_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         span_count++;
         if (pending_spans.size() == 0) begin
            $display("%0t: unexpected span %p", $time, rsp_data);
            error_count++;
         end else begin
            want = pending_spans.pop_front();
            if (want.span_valid) valid_span_count++;
            if (rsp_data.span_valid !== want.span_valid) begin
               $display("%0t: span_valid expected %0d actual %0d", $time,
                        want.span_valid, rsp_data.span_valid);
               error_count++;
            end
            if (rsp_data.span_left !== want.span_left) begin
               $display("%0t: span_left expected %0d actual %0d", $time,
                        want.span_left, rsp_data.span_left);
               error_count++;
            end
            if (rsp_data.span_right !== want.span_right) begin
               $display("%0t: span_right expected %0d actual %0d", $time,
                        want.span_right, rsp_data.span_right);
               error_count++;
            end
            if (rsp_data.span_color !== want.span_color) begin
               $display("%0t: span_color expected %h actual %h", $time,
                        want.span_color, rsp_data.span_color);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timeout: nothing accepted for %0d cycles", STALL_LIMIT);
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

>>> sim.f
rtl/tss_pkg.sv
rtl/tss_setup.sv
rtl/tss_div.sv
rtl/triangle_scanline_span_unit.sv
verif/triangle_scanline_span_unit_test.sv
